// ===== design/aabb_pkg.sv =====
// ============================================================================
// aabb_pkg
// Shared types, constants and helpers for the box push-out resolver: item
// structs, register indexes, controller states and datapath commands.
// ============================================================================
package aabb_pkg;

  // Box table depth and derived widths
  localparam int MAX_BOXES = 64;
  localparam int IDX_W     = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
  localparam int CNT_W     = $clog2(MAX_BOXES + 1);

  // Coordinate and register widths
  localparam int COORD_W = 32;
  localparam int EXT_W   = 35;   // room for coord +/- extent +/- margin
  localparam int HW_W    = 16;
  localparam int H_W     = 17;
  localparam int M_W     = 8;
  localparam int CFG_W   = 17;
  localparam int CFG_A_W = 2;

  // Register reset values (Q.8)
  localparam logic [HW_W-1:0] HW_RST = HW_W'(6400);
  localparam logic [H_W-1:0]  H_RST  = H_W'(12800);
  localparam logic [M_W-1:0]  M_RST  = M_W'(26);

  // Configuration register indexes
  localparam logic [CFG_A_W-1:0] CFG_HALF_WIDTH  = 2'd0;
  localparam logic [CFG_A_W-1:0] CFG_BOX_HEIGHT  = 2'd1;
  localparam logic [CFG_A_W-1:0] CFG_PUSH_MARGIN = 2'd2;

  // Opcodes
  localparam logic OP_ADD     = 1'b0;
  localparam logic OP_RESOLVE = 1'b1;

  // Result status codes
  localparam logic ST_DONE = 1'b0;
  localparam logic ST_FULL = 1'b1;

  typedef struct packed {
    logic                      opcode;
    logic signed [COORD_W-1:0] cur_x;
    logic signed [COORD_W-1:0] cur_y;
    logic signed [COORD_W-1:0] cur_z;
    logic signed [COORD_W-1:0] prev_x;
    logic signed [COORD_W-1:0] prev_y;
    logic signed [COORD_W-1:0] prev_z;
  } in_item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] out_x;
    logic signed [COORD_W-1:0] out_y;
    logic signed [COORD_W-1:0] out_z;
    logic                      status;
  } out_item_t;

  // One stored box
  typedef struct packed {
    logic signed [COORD_W-1:0] min_x;
    logic signed [COORD_W-1:0] min_y;
    logic signed [COORD_W-1:0] min_z;
    logic signed [COORD_W-1:0] max_x;
    logic signed [COORD_W-1:0] max_y;
    logic signed [COORD_W-1:0] max_z;
  } box_t;

  // Controller states
  typedef enum logic [3:0] {
    S_IDLE,
    S_ADD,
    S_RD,
    S_XMIN,
    S_XMAX,
    S_ZMIN,
    S_ZMAX,
    S_YMIN,
    S_YMAX,
    S_OUT
  } state_t;

  // Which face rule the datapath applies this cycle
  typedef enum logic [2:0] {
    RULE_XMIN,
    RULE_XMAX,
    RULE_ZMIN,
    RULE_ZMAX,
    RULE_YMIN,
    RULE_YMAX
  } rule_t;

  typedef struct packed {
    logic  load;     // capture the accepted item
    logic  add_wr;   // store the box, bump the count
    logic  rd_en;    // fetch a box into the read register
    logic  step;     // advance to the next box
    logic  push_en;  // apply the selected face rule
    rule_t rule;
  } dp_cmd_t;

  typedef struct packed {
    logic tbl_empty;
    logic last_box;
  } dp_stat_t;

  // Clamp a wide signed value into the signed 32-bit range
  function automatic logic signed [COORD_W-1:0] sat32(input logic signed [EXT_W-1:0] v);
    logic signed [COORD_W-1:0] r;
    if (v[EXT_W-1:COORD_W-1] == '0 || v[EXT_W-1:COORD_W-1] == '1) begin
      r = v[COORD_W-1:0];
    end else if (v[EXT_W-1]) begin
      r = {1'b1, {(COORD_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(COORD_W-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

// ===== design/aabb_push_out_resolver.sv =====
// ============================================================================
// aabb_push_out_resolver
// Swept box collision resolver: stores boxes and pushes a player position
// out of them, face by face, in insertion order.
// ============================================================================
// Usage: raise start with an item on in_data while busy is low; the item is
// taken at that edge and busy stays high until the result has been shown.
// The result appears on out_data for exactly one cycle with out_valid high
// and cannot be held off, so the receiver must capture it in that cycle.
// An add goes through the accept, add and strobe states. A resolve reads the
// first box, then one shared face-rule unit applies the x, z and y min/max
// rules to each stored box, one rule per cycle, with the next box fetched
// from the table during the last rule; with an empty table the strobe
// follows the accept directly. The next item can be accepted in the cycle
// after the strobe.
// Configuration registers are written through cfg_we/cfg_idx/cfg_wdata; the
// user must do so only while the block is idle, the block does not enforce it.
// ============================================================================
module aabb_push_out_resolver (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  aabb_pkg::in_item_t           in_data,
  output logic                         out_valid,
  output aabb_pkg::out_item_t          out_data,
  input  logic                         cfg_we,
  input  logic [aabb_pkg::CFG_A_W-1:0] cfg_idx,
  input  logic [aabb_pkg::CFG_W-1:0]   cfg_wdata
);

  aabb_pkg::dp_cmd_t  cmd;
  aabb_pkg::dp_stat_t stat;

  aabb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_opcode (in_data.opcode),
    .stat      (stat),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  aabb_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_data  (out_data)
  );

endmodule

// ===== design/aabb_ctrl.sv =====
// ============================================================================
// aabb_ctrl
// Controller for the push-out resolver: sequences add and resolve items and
// walks the box table six face rules per box.
// ============================================================================
module aabb_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               in_opcode,
  input  aabb_pkg::dp_stat_t stat,
  output aabb_pkg::dp_cmd_t  cmd,
  output logic               busy,
  output logic               out_valid
);

  aabb_pkg::state_t state_r;
  aabb_pkg::state_t state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= aabb_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      aabb_pkg::S_IDLE: begin
        if (start) begin
          if (in_opcode == aabb_pkg::OP_ADD) begin
            state_nxt = aabb_pkg::S_ADD;
          end else if (stat.tbl_empty) begin
            state_nxt = aabb_pkg::S_OUT;
          end else begin
            state_nxt = aabb_pkg::S_RD;
          end
        end
      end
      aabb_pkg::S_ADD:  state_nxt = aabb_pkg::S_OUT;
      aabb_pkg::S_RD:   state_nxt = aabb_pkg::S_XMIN;
      aabb_pkg::S_XMIN: state_nxt = aabb_pkg::S_XMAX;
      aabb_pkg::S_XMAX: state_nxt = aabb_pkg::S_ZMIN;
      aabb_pkg::S_ZMIN: state_nxt = aabb_pkg::S_ZMAX;
      aabb_pkg::S_ZMAX: state_nxt = aabb_pkg::S_YMIN;
      aabb_pkg::S_YMIN: state_nxt = aabb_pkg::S_YMAX;
      aabb_pkg::S_YMAX: begin
        state_nxt = stat.last_box ? aabb_pkg::S_OUT : aabb_pkg::S_XMIN;
      end
      aabb_pkg::S_OUT:  state_nxt = aabb_pkg::S_IDLE;
      default:          state_nxt = aabb_pkg::S_IDLE;
    endcase
  end

  // Outputs and datapath commands
  always_comb begin
    cmd       = '0;
    cmd.rule  = aabb_pkg::RULE_XMIN;
    busy      = 1'b1;
    out_valid = 1'b0;
    case (state_r)
      aabb_pkg::S_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      aabb_pkg::S_ADD: cmd.add_wr = 1'b1;
      aabb_pkg::S_RD:  cmd.rd_en  = 1'b1;
      aabb_pkg::S_XMIN: begin
        cmd.push_en = 1'b1;
        cmd.rule    = aabb_pkg::RULE_XMIN;
      end
      aabb_pkg::S_XMAX: begin
        cmd.push_en = 1'b1;
        cmd.rule    = aabb_pkg::RULE_XMAX;
      end
      aabb_pkg::S_ZMIN: begin
        cmd.push_en = 1'b1;
        cmd.rule    = aabb_pkg::RULE_ZMIN;
      end
      aabb_pkg::S_ZMAX: begin
        cmd.push_en = 1'b1;
        cmd.rule    = aabb_pkg::RULE_ZMAX;
      end
      aabb_pkg::S_YMIN: begin
        cmd.push_en = 1'b1;
        cmd.rule    = aabb_pkg::RULE_YMIN;
      end
      aabb_pkg::S_YMAX: begin
        cmd.push_en = 1'b1;
        cmd.rule    = aabb_pkg::RULE_YMAX;
        // prefetch the next box while finishing this one
        cmd.rd_en   = !stat.last_box;
        cmd.step    = !stat.last_box;
      end
      aabb_pkg::S_OUT: out_valid = 1'b1;
      default: busy = 1'b1;
    endcase
  end

  // Checks
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe lasted more than one cycle");

  a_idle_after_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !busy)
    else $error("block still busy after delivering a result");

  // a resolve on an empty table strobes right away, still busy
  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted item did not make the block busy");

endmodule

// ===== design/aabb_dp.sv =====
// ============================================================================
// aabb_dp
// Datapath for the push-out resolver: configuration registers, box table,
// position registers and the single face-rule unit.
// ============================================================================
module aabb_dp (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [aabb_pkg::CFG_A_W-1:0]   cfg_idx,
  input  logic [aabb_pkg::CFG_W-1:0]     cfg_wdata,
  input  aabb_pkg::in_item_t             in_data,
  input  aabb_pkg::dp_cmd_t              cmd,
  output aabb_pkg::dp_stat_t             stat,
  output aabb_pkg::out_item_t            out_data
);

  localparam int EW = aabb_pkg::EXT_W;

  // Configuration registers
  logic [aabb_pkg::HW_W-1:0] hw_r;
  logic [aabb_pkg::H_W-1:0]  h_r;
  logic [aabb_pkg::M_W-1:0]  m_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hw_r <= aabb_pkg::HW_RST;
      h_r  <= aabb_pkg::H_RST;
      m_r  <= aabb_pkg::M_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        aabb_pkg::CFG_HALF_WIDTH:  hw_r <= cfg_wdata[aabb_pkg::HW_W-1:0];
        aabb_pkg::CFG_BOX_HEIGHT:  h_r  <= cfg_wdata[aabb_pkg::H_W-1:0];
        aabb_pkg::CFG_PUSH_MARGIN: m_r  <= cfg_wdata[aabb_pkg::M_W-1:0];
        default: ;
      endcase
    end
  end

  // Item registers: position being resolved and previous position
  logic                               op_r;
  logic                               status_r;
  logic signed [aabb_pkg::COORD_W-1:0] x_r, y_r, z_r;
  logic signed [aabb_pkg::COORD_W-1:0] x_nxt, y_nxt, z_nxt;
  logic signed [aabb_pkg::COORD_W-1:0] px_r, py_r, pz_r;

  // Table control
  logic [aabb_pkg::CNT_W-1:0] cnt_r;
  logic [aabb_pkg::IDX_W-1:0] idx_r;
  logic                       full;

  assign full           = (cnt_r == aabb_pkg::CNT_W'(aabb_pkg::MAX_BOXES));
  assign stat.tbl_empty = (cnt_r == '0);
  assign stat.last_box  = ((aabb_pkg::CNT_W'(idx_r) + aabb_pkg::CNT_W'(1)) == cnt_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      idx_r <= '0;
    end else begin
      if (cmd.add_wr && !full) begin
        cnt_r <= cnt_r + aabb_pkg::CNT_W'(1);
      end
      if (cmd.load) begin
        idx_r <= '0;
      end else if (cmd.step) begin
        idx_r <= idx_r + aabb_pkg::IDX_W'(1);
      end
    end
  end

  // Box table, one write and one registered read per cycle
  aabb_pkg::box_t             mem [aabb_pkg::MAX_BOXES];
  aabb_pkg::box_t             box_r;
  aabb_pkg::box_t             wr_box;
  logic [aabb_pkg::IDX_W-1:0] rd_addr;

  assign wr_box  = '{min_x: x_r, min_y: y_r, min_z: z_r,
                     max_x: px_r, max_y: py_r, max_z: pz_r};
  assign rd_addr = cmd.step ? idx_r + aabb_pkg::IDX_W'(1) : idx_r;

  always_ff @(posedge clk) begin
    if (cmd.add_wr && !full) begin
      mem[cnt_r[aabb_pkg::IDX_W-1:0]] <= wr_box;
    end
    if (cmd.rd_en) begin
      box_r <= mem[rd_addr];
    end
  end

  // Extended operands
  logic signed [EW-1:0] hw_e, h_e, m_e;
  logic signed [EW-1:0] xe, ye, ze;
  logic signed [EW-1:0] nx, ny, nz, fx, fy, fz;

  assign hw_e = EW'($signed({1'b0, hw_r}));
  assign h_e  = EW'($signed({1'b0, h_r}));
  assign m_e  = EW'($signed({1'b0, m_r}));
  assign xe   = EW'(x_r);
  assign ye   = EW'(y_r);
  assign ze   = EW'(z_r);
  assign nx   = EW'(box_r.min_x);
  assign ny   = EW'(box_r.min_y);
  assign nz   = EW'(box_r.min_z);
  assign fx   = EW'(box_r.max_x);
  assign fy   = EW'(box_r.max_y);
  assign fz   = EW'(box_r.max_z);

  // Span overlap tests against the current box
  logic xov, yov, zov;
  assign xov = (xe - hw_e < fx) && (xe + hw_e > nx);
  assign yov = (ye < fy) && (ye + h_e > ny);
  assign zov = (ze - hw_e < fz) && (ze + hw_e > nz);

  // Operand select for the face rule of this cycle
  logic                 gate, min_rule;
  logic signed [EW-1:0] c, p, f, e;

  always_comb begin
    gate     = 1'b0;
    min_rule = 1'b1;
    c        = xe;
    p        = EW'(px_r);
    f        = nx;
    e        = hw_e;
    case (cmd.rule)
      aabb_pkg::RULE_XMIN: begin
        gate = yov && zov;
      end
      aabb_pkg::RULE_XMAX: begin
        gate     = yov && zov;
        min_rule = 1'b0;
        f        = fx;
      end
      aabb_pkg::RULE_ZMIN: begin
        gate = yov && xov;
        c    = ze;
        p    = EW'(pz_r);
        f    = nz;
      end
      aabb_pkg::RULE_ZMAX: begin
        gate     = yov && xov;
        min_rule = 1'b0;
        c        = ze;
        p        = EW'(pz_r);
        f        = fz;
      end
      aabb_pkg::RULE_YMIN: begin
        gate = zov && xov;
        c    = ye;
        p    = EW'(py_r);
        f    = ny;
        e    = h_e;
      end
      aabb_pkg::RULE_YMAX: begin
        gate     = zov && xov;
        min_rule = 1'b0;
        c        = ye;
        p        = EW'(py_r);
        f        = fy;
        e        = '0;
      end
      default: gate = 1'b0;
    endcase
  end

  // Crossing test and pushed coordinate
  logic                                hit;
  logic signed [aabb_pkg::COORD_W-1:0] pushed;

  always_comb begin
    if (min_rule) begin
      hit    = gate && (p + e < f) && (c + e > f);
      pushed = aabb_pkg::sat32(f - e - m_e);
    end else begin
      hit    = gate && (p - e > f) && (c - e < f);
      pushed = aabb_pkg::sat32(f + e + m_e);
    end
  end

  // Position update
  always_comb begin
    x_nxt = x_r;
    y_nxt = y_r;
    z_nxt = z_r;
    if (cmd.load) begin
      x_nxt = in_data.cur_x;
      y_nxt = in_data.cur_y;
      z_nxt = in_data.cur_z;
    end else if (cmd.push_en && hit) begin
      case (cmd.rule)
        aabb_pkg::RULE_XMIN, aabb_pkg::RULE_XMAX: x_nxt = pushed;
        aabb_pkg::RULE_ZMIN, aabb_pkg::RULE_ZMAX: z_nxt = pushed;
        aabb_pkg::RULE_YMIN, aabb_pkg::RULE_YMAX: y_nxt = pushed;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    x_r <= x_nxt;
    y_r <= y_nxt;
    z_r <= z_nxt;
    if (cmd.load) begin
      op_r     <= in_data.opcode;
      px_r     <= in_data.prev_x;
      py_r     <= in_data.prev_y;
      pz_r     <= in_data.prev_z;
      status_r <= aabb_pkg::ST_DONE;
    end else if (cmd.add_wr) begin
      status_r <= full ? aabb_pkg::ST_FULL : aabb_pkg::ST_DONE;
    end
  end

  // Result: add items report status only
  always_comb begin
    if (op_r == aabb_pkg::OP_RESOLVE) begin
      out_data = '{out_x: x_r, out_y: y_r, out_z: z_r, status: aabb_pkg::ST_DONE};
    end else begin
      out_data = '{out_x: '0, out_y: '0, out_z: '0, status: status_r};
    end
  end

  // Checks
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= aabb_pkg::CNT_W'(aabb_pkg::MAX_BOXES))
    else $error("box count beyond table depth");

  a_full_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.add_wr && full) |=> (cnt_r == $past(cnt_r)))
    else $error("add to a full table changed the count");

  a_walk_in_table: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push_en |-> (aabb_pkg::CNT_W'(idx_r) < cnt_r))
    else $error("face rule applied past the last stored box");

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// ============================================================================
// testbench
// Self-checking bench for the box push-out resolver. A directed table covers
// the empty table, every face push, saturation at both ends of the range,
// inverted and unbounded boxes. Random traffic near stored boxes follows,
// under several register settings, and then the table is filled to capacity.
// Every result is compared field by field against a typed expected value or a bench-side predictor.
// ============================================================================
module testbench;

  localparam int     CLK_HALF      = 10;
  localparam int     RESET_CYCLES  = 7;
  localparam int     IDLE_LIMIT    = 2000;
  localparam int     NUM_PHASES    = 7;
  localparam int     PHASE_ITEMS   = 230;
  localparam int     FULL_REJECTS  = 8;
  localparam int     FULL_RESOLVES = 60;
  localparam longint WORLD         = 400000;
  localparam longint BOX_SPAN      = 40000;
  localparam longint PAD           = 3000;
  localparam longint S32_MAX       = 64'sd2147483647;
  localparam longint S32_MIN       = -64'sd2147483648;
  localparam longint EDGE_B        = 25600;  // 100.0, side of the first test box
  localparam longint MID_B         = 12800;  // 50.0, its center
  localparam logic [aabb_pkg::CFG_A_W-1:0] CFG_UNUSED = 2'd3;

  typedef struct {
    aabb_pkg::in_item_t  item;
    bit                  typed;
    aabb_pkg::out_item_t want;
  } dir_row_t;

  logic                          clk = 1'b0;
  logic                          rst_n;
  logic                          start;
  logic                          busy;
  aabb_pkg::in_item_t            in_data;
  logic                          out_valid;
  aabb_pkg::out_item_t           out_data;
  logic                          cfg_we;
  logic [aabb_pkg::CFG_A_W-1:0]  cfg_idx;
  logic [aabb_pkg::CFG_W-1:0]    cfg_wdata;

  // Shadow of the block: stored boxes and registers
  aabb_pkg::box_t                box_tbl [aabb_pkg::MAX_BOXES];
  int                            box_fill = 0;
  logic [aabb_pkg::HW_W-1:0]     hw_q = aabb_pkg::HW_RST;
  logic [aabb_pkg::H_W-1:0]      h_q  = aabb_pkg::H_RST;
  logic [aabb_pkg::M_W-1:0]      m_q  = aabb_pkg::M_RST;

  aabb_pkg::out_item_t           expected_pos [$];
  aabb_pkg::out_item_t           oldest_pos;
  dir_row_t                      dir_rows [$];
  int                            mismatch_cnt = 0;
  int                            idle_cycles  = 0;
  int                            burst_left   = 0;

  aabb_push_out_resolver i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  function automatic logic signed [aabb_pkg::COORD_W-1:0] clamp32(input longint v);
    if (v > S32_MAX) return S32_MAX[aabb_pkg::COORD_W-1:0];
    if (v < S32_MIN) return S32_MIN[aabb_pkg::COORD_W-1:0];
    return v[aabb_pkg::COORD_W-1:0];
  endfunction

  // Store a box, or walk the table and push the player out face by face
  function automatic aabb_pkg::out_item_t predict_item(input aabb_pkg::in_item_t it);
    aabb_pkg::out_item_t res;
    longint    x, y, z, px, py, pz, hw, h, m;
    longint    nx, ny, nz, fx, fy, fz;
    res = '0;
    if (it.opcode == aabb_pkg::OP_ADD) begin
      if (box_fill < aabb_pkg::MAX_BOXES) begin
        box_tbl[box_fill] = '{it.cur_x, it.cur_y, it.cur_z, it.prev_x, it.prev_y, it.prev_z};
        box_fill++;
        res.status = aabb_pkg::ST_DONE;
      end else begin
        res.status = aabb_pkg::ST_FULL;
      end
      return res;
    end
    x  = longint'(it.cur_x);  y  = longint'(it.cur_y);  z  = longint'(it.cur_z);
    px = longint'(it.prev_x); py = longint'(it.prev_y); pz = longint'(it.prev_z);
    hw = longint'(hw_q); h = longint'(h_q); m = longint'(m_q);
    for (int i = 0; i < box_fill; i++) begin
      nx = longint'(box_tbl[i].min_x);
      ny = longint'(box_tbl[i].min_y);
      nz = longint'(box_tbl[i].min_z);
      fx = longint'(box_tbl[i].max_x);
      fy = longint'(box_tbl[i].max_y);
      fz = longint'(box_tbl[i].max_z);
      if (y < fy && y + h > ny) begin
        if (z - hw < fz && z + hw > nz) begin
          if (px + hw < nx && x + hw > nx) x = clamp32(nx - hw - m);
          if (px - hw > fx && x - hw < fx) x = clamp32(fx + hw + m);
        end
        if (x - hw < fx && x + hw > nx) begin
          if (pz + hw < nz && z + hw > nz) z = clamp32(nz - hw - m);
          if (pz - hw > fz && z - hw < fz) z = clamp32(fz + hw + m);
        end
      end
      if (z - hw < fz && z + hw > nz && x - hw < fx && x + hw > nx) begin
        if (py + h < ny && y + h > ny) y = clamp32(ny - h - m);
        if (py > fy && y < fy) y = clamp32(fy + m);
      end
    end
    res.out_x  = x[aabb_pkg::COORD_W-1:0];
    res.out_y  = y[aabb_pkg::COORD_W-1:0];
    res.out_z  = z[aabb_pkg::COORD_W-1:0];
    res.status = aabb_pkg::ST_DONE;
    return res;
  endfunction

  function automatic longint rand_between(input longint lo, input longint hi);
    longint unsigned r, span;
    r    = {$urandom(), $urandom()};
    span = hi - lo + 1;
    return lo + longint'(r % span);
  endfunction

  // One axis of a move: current position near the box, previous one a step away
  function automatic void pick_axis(input longint lo, input longint hi,
                                    input longint below, input longint above,
                                    output logic signed [aabb_pkg::COORD_W-1:0] cur,
                                    output logic signed [aabb_pkg::COORD_W-1:0] prev);
    longint c, span;
    c    = rand_between(lo - below - PAD, hi + above + PAD);
    span = (hi - lo) + below + above + 2 * PAD;
    cur  = clamp32(c);
    if ($urandom_range(0, 2) == 0) prev = cur;
    else prev = clamp32(c + rand_between(-span, span));
  endfunction

  function automatic aabb_pkg::in_item_t noise_item(input bit allow_add);
    aabb_pkg::in_item_t it;
    it.opcode = (allow_add && $urandom_range(0, 7) == 0) ? aabb_pkg::OP_ADD
                                                         : aabb_pkg::OP_RESOLVE;
    it.cur_x  = $urandom();
    it.cur_y  = $urandom();
    it.cur_z  = $urandom();
    it.prev_x = $urandom();
    it.prev_y = $urandom();
    it.prev_z = $urandom();
    return it;
  endfunction

  function automatic aabb_pkg::in_item_t make_box(input bit inverted);
    aabb_pkg::in_item_t it;
    longint   x0, y0, z0, x1, y1, z1;
    x0 = rand_between(-WORLD, WORLD);
    y0 = rand_between(-WORLD, WORLD);
    z0 = rand_between(-WORLD, WORLD);
    x1 = x0 + rand_between(longint'(0), BOX_SPAN);
    y1 = y0 + rand_between(longint'(0), BOX_SPAN);
    z1 = z0 + rand_between(longint'(0), BOX_SPAN);
    it.opcode = aabb_pkg::OP_ADD;
    if (inverted) begin
      it.cur_x = x1[31:0]; it.cur_y = y1[31:0]; it.cur_z = z1[31:0];
      it.prev_x = x0[31:0]; it.prev_y = y0[31:0]; it.prev_z = z0[31:0];
    end else begin
      it.cur_x = x0[31:0]; it.cur_y = y0[31:0]; it.cur_z = z0[31:0];
      it.prev_x = x1[31:0]; it.prev_y = y1[31:0]; it.prev_z = z1[31:0];
    end
    return it;
  endfunction

  // A move aimed at one stored box, so that faces get crossed often
  function automatic aabb_pkg::in_item_t aimed_move();
    aabb_pkg::in_item_t it;
    aabb_pkg::box_t     b;
    if (box_fill == 0) return noise_item(1'b0);
    b = box_tbl[$urandom_range(0, box_fill - 1)];
    it.opcode = aabb_pkg::OP_RESOLVE;
    pick_axis(longint'((b.min_x < b.max_x) ? b.min_x : b.max_x),
              longint'((b.min_x < b.max_x) ? b.max_x : b.min_x),
              longint'(hw_q), longint'(hw_q), it.cur_x, it.prev_x);
    pick_axis(longint'((b.min_y < b.max_y) ? b.min_y : b.max_y),
              longint'((b.min_y < b.max_y) ? b.max_y : b.min_y),
              longint'(h_q), longint'(0), it.cur_y, it.prev_y);
    pick_axis(longint'((b.min_z < b.max_z) ? b.min_z : b.max_z),
              longint'((b.min_z < b.max_z) ? b.max_z : b.min_z),
              longint'(hw_q), longint'(hw_q), it.cur_z, it.prev_z);
    return it;
  endfunction

  // Hand one item over and record what it should produce
  task automatic issue(input aabb_pkg::in_item_t it, input bit typed,
                       input aabb_pkg::out_item_t typed_res);
    aabb_pkg::out_item_t pred;
    aabb_pkg::out_item_t want;
    in_data <= it;
    start   <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    pred = predict_item(it);
    want = typed ? typed_res : pred;
    expected_pos = {expected_pos, want};
  endtask

  // Sender bursts with random gaps, now and then a long run without gaps
  task automatic pace();
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk);
    while (expected_pos.size() != 0 || busy) @(posedge clk);
  endtask

  task automatic write_reg(input logic [aabb_pkg::CFG_A_W-1:0] idx,
                           input logic [aabb_pkg::CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      aabb_pkg::CFG_HALF_WIDTH:  hw_q = val[aabb_pkg::HW_W-1:0];
      aabb_pkg::CFG_BOX_HEIGHT:  h_q  = val[aabb_pkg::H_W-1:0];
      aabb_pkg::CFG_PUSH_MARGIN: m_q  = val[aabb_pkg::M_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_regs(input logic [aabb_pkg::CFG_W-1:0] hw,
                          input logic [aabb_pkg::CFG_W-1:0] h,
                          input logic [aabb_pkg::CFG_W-1:0] m, input bit poke_unused);
    wait_idle();
    write_reg(aabb_pkg::CFG_HALF_WIDTH, hw);
    write_reg(aabb_pkg::CFG_BOX_HEIGHT, h);
    write_reg(aabb_pkg::CFG_PUSH_MARGIN, m);
    if (poke_unused) write_reg(CFG_UNUSED, aabb_pkg::CFG_W'($urandom()));
    cfg_we <= 1'b0;
  endtask

  task automatic add_row(input logic op, input longint cx, input longint cy, input longint cz,
                         input longint px, input longint py, input longint pz,
                         input bit typed, input longint wx, input longint wy,
                         input longint wz, input logic ws);
    dir_row_t r;
    r.item  = '{op, cx[31:0], cy[31:0], cz[31:0], px[31:0], py[31:0], pz[31:0]};
    r.typed = typed;
    r.want  = '{wx[31:0], wy[31:0], wz[31:0], ws};
    dir_rows = {dir_rows, r};
  endtask

  function automatic void report_field(input string name, input longint want, input longint got);
    mismatch_cnt++;
    $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
  endfunction

  // Result checker: the block cannot be stalled, so every strobe is taken
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1) begin
      if (expected_pos.size() == 0) begin
        mismatch_cnt++;
        $display("%0t: unexpected result: expected none, actual %p", $time, out_data);
      end else begin
        oldest_pos = expected_pos.pop_front();
        if (out_data.out_x !== oldest_pos.out_x)
          report_field("out_x", longint'(oldest_pos.out_x), longint'(out_data.out_x));
        if (out_data.out_y !== oldest_pos.out_y)
          report_field("out_y", longint'(oldest_pos.out_y), longint'(out_data.out_y));
        if (out_data.out_z !== oldest_pos.out_z)
          report_field("out_z", longint'(oldest_pos.out_z), longint'(out_data.out_z));
        if (out_data.status !== oldest_pos.status)
          report_field("status", longint'(oldest_pos.status), longint'(out_data.status));
      end
    end
  end

  // Watchdog: quiet cycles with no item taken and no result shown
  always @(posedge clk) begin
    if ((start === 1'b1 && busy === 1'b0) || out_valid === 1'b1) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Stimulus
  initial begin
    int                 cap;
    int                 pick;
    int                 rejected;
    int                 resolves;
    aabb_pkg::in_item_t item;

    rst_n     = 1'b0;
    start     = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_idx   = '0;
    cfg_wdata = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, register reset values: empty table first
    add_row(aabb_pkg::OP_RESOLVE, 100, 200, 300, -5, -6, -7,
            1, 100, 200, 300, aabb_pkg::ST_DONE);
    add_row(aabb_pkg::OP_RESOLVE, S32_MAX, S32_MIN, S32_MAX, S32_MIN, S32_MAX, S32_MIN,
            1, S32_MAX, S32_MIN, S32_MAX, aabb_pkg::ST_DONE);
    add_row(aabb_pkg::OP_ADD, 0, 0, 0, EDGE_B, EDGE_B, EDGE_B, 1, 0, 0, 0, aabb_pkg::ST_DONE);
    // inverted box, stored as given
    add_row(aabb_pkg::OP_ADD, 1000000, 1000000, 1000000, 900000, 900000, 900000,
            1, 0, 0, 0, aabb_pkg::ST_DONE);
    // each face of the first box
    add_row(aabb_pkg::OP_RESOLVE, -1000, 100, MID_B, -40000, 100, MID_B,
            0, 0, 0, 0, aabb_pkg::ST_DONE);
    add_row(aabb_pkg::OP_RESOLVE, 30000, 100, MID_B, 60000, 100, MID_B,
            0, 0, 0, 0, aabb_pkg::ST_DONE);
    add_row(aabb_pkg::OP_RESOLVE, MID_B, 100, -1000, MID_B, 100, -40000,
            0, 0, 0, 0, aabb_pkg::ST_DONE);
    add_row(aabb_pkg::OP_RESOLVE, MID_B, 100, 30000, MID_B, 100, 60000,
            0, 0, 0, 0, aabb_pkg::ST_DONE);
    add_row(aabb_pkg::OP_RESOLVE, MID_B, -5000, MID_B, MID_B, -20000, MID_B,
            0, 0, 0, 0, aabb_pkg::ST_DONE);
    add_row(aabb_pkg::OP_RESOLVE, MID_B, 20000, MID_B, MID_B, 30000, MID_B,
            0, 0, 0, 0, aabb_pkg::ST_DONE);
    // crossing in x but far above the box: no push
    add_row(aabb_pkg::OP_RESOLVE, -1000, 100000, MID_B, -40000, 100000, MID_B,
            0, 0, 0, 0, aabb_pkg::ST_DONE);
    // box spanning the whole range
    add_row(aabb_pkg::OP_ADD, S32_MIN, S32_MIN, S32_MIN, S32_MAX, S32_MAX, S32_MAX,
            1, 0, 0, 0, aabb_pkg::ST_DONE);
    // pushes that saturate, low and high x
    add_row(aabb_pkg::OP_ADD, S32_MIN + 6401, 0, 0, S32_MIN + 100000, EDGE_B, EDGE_B,
            1, 0, 0, 0, aabb_pkg::ST_DONE);
    add_row(aabb_pkg::OP_RESOLVE, S32_MIN + 6411, 100, MID_B, S32_MIN, 100, MID_B,
            0, 0, 0, 0, aabb_pkg::ST_DONE);
    add_row(aabb_pkg::OP_ADD, S32_MAX - 100000, 0, 0, S32_MAX - 6401, EDGE_B, EDGE_B,
            1, 0, 0, 0, aabb_pkg::ST_DONE);
    add_row(aabb_pkg::OP_RESOLVE, S32_MAX - 6411, 100, MID_B, S32_MAX, 100, MID_B,
            0, 0, 0, 0, aabb_pkg::ST_DONE);
    // pushes that saturate, high and low y
    add_row(aabb_pkg::OP_ADD, 0, S32_MAX - 100000, 0, EDGE_B, S32_MAX - 5, EDGE_B,
            1, 0, 0, 0, aabb_pkg::ST_DONE);
    add_row(aabb_pkg::OP_RESOLVE, MID_B, S32_MAX - 50, MID_B, MID_B, S32_MAX, MID_B,
            0, 0, 0, 0, aabb_pkg::ST_DONE);
    add_row(aabb_pkg::OP_ADD, 0, S32_MIN + 12801, 0, EDGE_B, S32_MIN + 100000, EDGE_B,
            1, 0, 0, 0, aabb_pkg::ST_DONE);
    add_row(aabb_pkg::OP_RESOLVE, MID_B, S32_MIN + 7801, MID_B, MID_B, S32_MIN, MID_B,
            0, 0, 0, 0, aabb_pkg::ST_DONE);
    add_row(aabb_pkg::OP_RESOLVE, 0, 0, 0, -1, -1, -1, 0, 0, 0, 0, aabb_pkg::ST_DONE);

    foreach (dir_rows[i]) begin
      pace();
      issue(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);
    end

    // Random part, one register setting per phase; the table grows slowly
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: ;
        1: set_regs('0, '0, '0, 1'b0);
        2: set_regs('1, '1, '1, 1'b0);
        3: set_regs(aabb_pkg::CFG_W'(aabb_pkg::HW_RST), aabb_pkg::CFG_W'(aabb_pkg::H_RST),
                    aabb_pkg::CFG_W'(aabb_pkg::M_RST), 1'b0);
        default: set_regs(aabb_pkg::CFG_W'($urandom()), aabb_pkg::CFG_W'($urandom()),
                          aabb_pkg::CFG_W'($urandom()), ph == 4);
      endcase
      cap = 12 + 4 * ph;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        pace();
        pick = $urandom_range(0, 99);
        if (pick < 3 && box_fill < cap) item = make_box(1'b0);
        else if (pick == 3 && box_fill < cap) item = make_box(1'b1);
        else if (pick < 14) item = noise_item(box_fill < cap);
        else item = aimed_move();
        issue(item, 1'b0, '0);
        if ($urandom_range(0, 149) == 0) wait_idle();
      end
    end

    // Fill the table, hit the full-table rejection, resolve with all boxes stored
    rejected = 0;
    resolves = 0;
    while (box_fill < aabb_pkg::MAX_BOXES || rejected < FULL_REJECTS ||
           resolves < FULL_RESOLVES) begin
      pace();
      if (box_fill < aabb_pkg::MAX_BOXES
          ? $urandom_range(0, 1) == 0
          : (rejected < FULL_REJECTS && $urandom_range(0, 5) == 0)) begin
        if (box_fill == aabb_pkg::MAX_BOXES) rejected++;
        item = make_box($urandom_range(0, 9) == 0);
      end else begin
        if (box_fill == aabb_pkg::MAX_BOXES) resolves++;
        item = ($urandom_range(0, 9) == 0) ? noise_item(1'b0) : aimed_move();
      end
      issue(item, 1'b0, '0);
    end

    // Drain, then allow the pipeline to settle
    start <= 1'b0;
    while (expected_pos.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatch_cnt == 0 && expected_pos.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
